>>> hdl/zobrist_position_hasher_top_assert.svh
// Assertion macros for the Zobrist position hasher.
`ifndef ZOBRIST_POSITION_HASHER_TOP_ASSERT_SVH
`define ZOBRIST_POSITION_HASHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ZPH_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ZPH_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ZPH_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define ZPH_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

>>> hdl/zph_pkg.sv
// ----------------------------------------------------------------------------
// zph_pkg
// Shared constants, opcodes and types for the Zobrist position hasher.
// ----------------------------------------------------------------------------
package zph_pkg;
    localparam int NUM_COLORS_DEF      = 2;
    localparam int NUM_PIECE_TYPES_DEF = 6;
    localparam logic [63:0] SEED_RESET = 64'h0000_0000_00C0_FFEE;
    localparam logic [3:0]  CASTLE_MASK = 4'hF;

    localparam logic [2:0] OP_PIECE  = 3'd0;
    localparam logic [2:0] OP_SIDE   = 3'd1;
    localparam logic [2:0] OP_CASTLE = 3'd2;
    localparam int MT_N = 312;
    localparam int MT_M = 156;
    localparam logic [2:0] OP_EP     = 3'd3;
    localparam logic [2:0] OP_FINISH = 3'd4;

    localparam logic [63:0] MT_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] MT_MULT   = 64'd6364136223846793005;

    function automatic logic [63:0] mt_temper(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
        x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
        x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
        x = x ^ (x >> 43);
        return x;
    endfunction

    function automatic logic [63:0] mt_twist(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] y;
        x = {a[63:31], b[30:0]};
        y = x >> 1;
        if (x[0])
        begin
            y = y ^ MT_MATRIX;
        end
        return m ^ y;
    endfunction

    typedef struct packed {
        logic       busy;
        logic       wr_en;
    } fill_status_t;
endpackage

>>> hdl/zph_stream_if.sv
// ----------------------------------------------------------------------------
// zph_term_if / zph_result_if
// Valid/ready channels carrying position terms and hash results.
// ----------------------------------------------------------------------------
interface zph_term_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic       color;
    logic [2:0] pc_kind;
    logic [5:0] square;
    logic       side_white;
    logic [3:0] castling;
    logic       ep_present;
    logic [2:0] ep_file;
    modport source (output valid, opcode, color, pc_kind, square, side_white,
                    castling, ep_present, ep_file, input ready);
    modport sink (input valid, opcode, color, pc_kind, square, side_white,
                  castling, ep_present, ep_file, output ready);
endinterface

interface zph_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] key;
    logic [63:0] hash;
    logic        done_res;
    modport source (output valid, key, hash, done_res, input ready);
    modport sink (input valid, key, hash, done_res, output ready);
endinterface

>>> hdl/zph_key_gen.sv
// ----------------------------------------------------------------------------
// zph_key_gen
// MT19937-64 generator: seeds its state one word at a time with a
// shared multiplier, twists it in place, then streams tempered words into the
// key table one by one, twisting again whenever the state is used up.
// ----------------------------------------------------------------------------
module zph_key_gen #(
    parameter int TABLE_SIZE = 793,
    parameter int AW = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              seed,
    output zph_pkg::fill_status_t    status,
    output logic [AW-1:0]            wr_addr,
    output logic [63:0]              wr_data
);
    import zph_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEED  = 3'd1;
    localparam logic [2:0] S_TWIST = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam int IW = $clog2(MT_N);
    localparam logic [31:0] MULT_LO = MT_MULT[31:0];
    localparam logic [31:0] MULT_HI = MT_MULT[63:32];

    // The state memory has one write and two read ports; the twist reads
    // word i+1 and word i+M while it writes word i.
    logic [63:0] mt_mem [MT_N];

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [1:0]    phase_reg, phase_next;
    logic [63:0]   prev_reg, prev_next;
    logic [63:0]   mix;
    logic [63:0]   pp_lo_reg;
    logic [31:0]   pp_hi_reg;
    logic [63:0]   prod;
    logic [63:0]   cur_reg;
    logic [63:0]   rd_a_reg, rd_b_reg;
    logic [IW-1:0] ra_addr, rb_addr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input int b);
        int s;
        s = int'(a) + b;
        if (s >= MT_N)
        begin
            s = s - MT_N;
        end
        return IW'(s);
    endfunction

    // The 64-bit product modulo 2^64 is built from three 32x32 partial products.
    assign mix  = prev_reg ^ (prev_reg >> 62);
    assign prod = pp_lo_reg + {pp_hi_reg, 32'd0};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mt_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg  <= mt_mem[ra_addr];
        rd_b_reg  <= mt_mem[rb_addr];
        pp_lo_reg <= mix[31:0] * MULT_LO;
        pp_hi_reg <= mix[31:0] * MULT_HI + mix[63:32] * MULT_LO;
    end

    // Twist, per word i: phase 0 reads word i, phases 1 and 2 read words i+1
    // and i+M, phase 3 writes word i.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        prev_next  = prev_reg;
        ra_addr    = wrap_add(idx_reg, 1);
        rb_addr    = wrap_add(idx_reg, MT_M);
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = prev_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = seed;
                prev_next = seed;
                idx_next  = IW'(1);
                cnt_next  = '0;
                phase_next = 2'd0;
                state_next = S_SEED;
            end
            S_SEED:
            begin
                // phase 0: product launches from prev_reg; phase 1: write it.
                if (phase_reg == 2'd0)
                begin
                    phase_next = 2'd1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = prod + 64'(idx_reg);
                    prev_next = prod + 64'(idx_reg);
                    phase_next = 2'd0;
                    if (int'(idx_reg) == MT_N - 1)
                    begin
                        idx_next   = '0;
                        state_next = S_TWIST;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            S_TWIST:
            begin
                if (phase_reg == 2'd0)
                begin
                    ra_addr    = idx_reg;
                    phase_next = 2'd1;
                end
                else if (phase_reg == 2'd1)
                begin
                    phase_next = 2'd2;
                end
                else if (phase_reg == 2'd2)
                begin
                    phase_next = 2'd3;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mt_twist(cur_reg, rd_a_reg, rd_b_reg);
                    phase_next = 2'd0;
                    if (int'(idx_reg) == MT_N - 1)
                    begin
                        idx_next   = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            S_FILL:
            begin
                ra_addr = idx_reg;
                if (phase_reg == 2'd0)
                begin
                    phase_next = 2'd1;
                end
                else
                begin
                    // Table words beyond one twist block restart the twist.
                    cnt_next = cnt_reg + AW'(1);
                    if (int'(cnt_reg) == TABLE_SIZE - 1)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (int'(idx_reg) == MT_N - 1)
                    begin
                        idx_next   = '0;
                        phase_next = 2'd0;
                        state_next = S_TWIST;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        phase_next = 2'd0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = S_START;
        end
    end

    // In twist phase 1 port A returned word i; then port A rereads word i+1.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TWIST && phase_reg == 2'd1)
        begin
            cur_reg <= rd_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

    assign status.busy  = (state_reg != S_IDLE) || start;
    assign status.wr_en = (state_reg == S_FILL) && (phase_reg == 2'd1);
    assign wr_addr = cnt_reg;
    assign wr_data = mt_temper(rd_a_reg);
endmodule

>>> hdl/zph_term_unit.sv
// ----------------------------------------------------------------------------
// zph_term_unit
// Holds the key table, looks up one term a cycle unless stalled, folds it into the hash.
// ----------------------------------------------------------------------------
`include "zobrist_position_hasher_top_assert.svh"
module zph_term_unit #(
    parameter int NUM_COLORS = 2,
    parameter int NUM_PIECE_TYPES = 6,
    parameter int TABLE_SIZE = 793,
    parameter int AW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  zph_pkg::fill_status_t fill,
    input  logic [AW-1:0]         wr_addr,
    input  logic [63:0]           wr_data,
    zph_term_if.sink              term,
    zph_result_if.source          result
);
    import zph_pkg::*;

    localparam int PIECE_KEYS  = NUM_COLORS * NUM_PIECE_TYPES * 64;
    localparam int SIDE_BASE   = PIECE_KEYS;
    localparam int CASTLE_BASE = SIDE_BASE + 1;
    localparam int EP_BASE     = CASTLE_BASE + 16;

    logic [63:0] key_mem [TABLE_SIZE];

    logic          s1_valid_reg;
    logic [63:0]   s1_data_reg;
    logic          s1_zero_reg;
    logic          s1_fin_reg;
    logic          out_valid_reg;
    logic [63:0]   key_reg, hash_reg, run_reg;
    logic          done_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_hit;
    logic          adv;
    logic          s1_adv;
    logic [63:0]   s1_key;
    logic [63:0]   run_next;

    // Stage 1 is the registered table read; output register follows.
    assign adv    = !out_valid_reg || result.ready;
    assign s1_adv = !s1_valid_reg || adv;
    assign term.ready = s1_adv && !fill.busy;

    always_comb
    begin
        rd_addr = '0;
        rd_hit  = 1'b0;
        case (term.opcode)
            OP_PIECE:
            begin
                rd_hit = (int'(term.color) < NUM_COLORS) &&
                         (int'(term.pc_kind) < NUM_PIECE_TYPES);
                rd_addr = AW'((int'(term.color) * NUM_PIECE_TYPES + int'(term.pc_kind))
                              * 64 + int'(term.square));
            end
            OP_SIDE:
            begin
                rd_hit  = term.side_white;
                rd_addr = AW'(SIDE_BASE);
            end
            OP_CASTLE:
            begin
                rd_hit  = 1'b1;
                rd_addr = AW'(CASTLE_BASE + int'(term.castling & CASTLE_MASK));
            end
            OP_EP:
            begin
                rd_hit  = term.ep_present;
                rd_addr = AW'(EP_BASE + int'(term.ep_file));
            end
            default:
            begin
                rd_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fill.wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (term.valid && term.ready)
        begin
            s1_data_reg <= key_mem[rd_addr];
            s1_zero_reg <= !rd_hit;
            s1_fin_reg  <= (term.opcode == OP_FINISH);
        end
    end

    assign s1_key   = s1_zero_reg ? 64'd0 : s1_data_reg;
    assign run_next = s1_fin_reg ? 64'd0 : (run_reg ^ s1_key);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && adv)
        begin
            key_reg  <= s1_key;
            hash_reg <= s1_fin_reg ? run_reg : (run_reg ^ s1_key);
            done_reg <= s1_fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_reg       <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= term.valid && term.ready;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && adv)
            begin
                run_reg <= run_next;
            end
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.key      = key_reg;
    assign result.hash     = hash_reg;
    assign result.done_res = done_reg;

    `ZPH_ASSERT_IMP(a_no_take_in_fill, clk, rst_n, fill.busy, !term.ready, "accept in fill")
    `ZPH_ASSERT_NXT(a_out_hold, clk, rst_n, result.valid && !result.ready, result.valid,
                    "result dropped")
    `ZPH_ASSERT_IMP(a_fin_key, clk, rst_n, result.valid && result.done_res, result.key == 64'd0,
                    "finish key nonzero")
endmodule

>>> hdl/zobrist_position_hasher_top.sv
// ----------------------------------------------------------------------------
// zobrist_position_hasher_top
// Zobrist hasher for chess positions with an MT19937-64 key table.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// term      in         opcode, color, pc_kind, square, side_white,
//                      castling, ep_present, ep_file
// result    out        key, hash, done_res
//
// One term per cycle unless stalled, through the table read and output register.
// After reset, and after a seed write, the generator refills the key table: it
// seeds its state, twists it, and streams tempered words, twisting again as
// the state runs out. term.ready stays low for that time.
// A stalled result holds both stages.
module zobrist_position_hasher_top #(
    parameter int NUM_COLORS = zph_pkg::NUM_COLORS_DEF,
    parameter int NUM_PIECE_TYPES = zph_pkg::NUM_PIECE_TYPES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [63:0] seed_wdata,
    zph_term_if.sink    term,
    zph_result_if.source result
);
    import zph_pkg::*;

    localparam int TABLE_SIZE = NUM_COLORS * NUM_PIECE_TYPES * 64 + 25;
    localparam int AW = $clog2(TABLE_SIZE);

    fill_status_t  fill;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [63:0]   seed_reg;
    logic          start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= SEED_RESET;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= seed_we;
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
        end
    end

    zph_key_gen #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_gen (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .seed(seed_reg),
        .status(fill), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    zph_term_unit #(.NUM_COLORS(NUM_COLORS), .NUM_PIECE_TYPES(NUM_PIECE_TYPES),
                    .TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_term (
        .clk(clk), .rst_n(rst_n), .fill(fill), .wr_addr(wr_addr), .wr_data(wr_data),
        .term(term), .result(result)
    );
endmodule

>>> bench/zph_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_tb_if
// Testbench-side copies of the term and result channels are not needed; the
// bench uses the block's own interfaces. This file holds the bench's helper
// types for the hash checker.
// ----------------------------------------------------------------------------
package zph_tb_pkg;
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] hash;
        logic        done_res;
    } hash_result_t;
endpackage

>>> bench/zph_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_hash_checker
// Watches the term and result channels, keeps its own MT19937-64 key table
// and running hash, and compares every result transfer with the prediction.
// ----------------------------------------------------------------------------
module zph_hash_checker #(
    parameter int NUM_COLORS = 2,
    parameter int NUM_PIECE_TYPES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [63:0] seed_wdata,
    zph_term_if         term,
    zph_result_if       result,
    output int          fail_count,
    output int          pending
);
    import zph_pkg::*;
    import zph_tb_pkg::*;

    localparam int PIECE_KEYS = NUM_COLORS * NUM_PIECE_TYPES * 64;
    localparam int SIDE_BASE = PIECE_KEYS;
    localparam int CASTLE_BASE = SIDE_BASE + 1;
    localparam int EP_BASE = CASTLE_BASE + 16;
    localparam int TABLE_SIZE = EP_BASE + 8;

    logic [63:0] zkeys[TABLE_SIZE];
    logic [63:0] mt[MT_N];
    int unsigned mt_pos;
    logic [63:0] pos_hash;
    hash_result_t hash_q[$];

    function automatic logic [63:0] mt_draw();
        logic [63:0] x;
        logic [63:0] y;
        if (mt_pos >= MT_N)
        begin
            for (int i = 0; i < MT_N; i++)
            begin
                x = {mt[i][63:31], mt[(i + 1) % MT_N][30:0]};
                y = x >> 1;
                if (x[0])
                    y = y ^ 64'hB502_6F5A_A966_19E9;
                mt[i] = mt[(i + MT_M) % MT_N] ^ y;
            end
            mt_pos = 0;
        end
        x = mt[mt_pos];
        mt_pos++;
        x ^= (x >> 29) & 64'h5555_5555_5555_5555;
        x ^= (x << 17) & 64'h71D6_7FFF_EDA6_0000;
        x ^= (x << 37) & 64'hFFF7_EEE0_0000_0000;
        x ^= x >> 43;
        return x;
    endfunction

    function automatic void build_keys(input logic [63:0] s);
        mt[0] = s;
        for (int i = 1; i < MT_N; i++)
            mt[i] = 64'd6364136223846793005 * (mt[i - 1] ^ (mt[i - 1] >> 62)) + 64'(i);
        mt_pos = MT_N;
        for (int i = 0; i < TABLE_SIZE; i++)
            zkeys[i] = mt_draw();
    endfunction

    function automatic hash_result_t hash_term(input logic [2:0] op, input logic c,
                                               input logic [2:0] pt, input logic [5:0] sq,
                                               input logic sw, input logic [3:0] cr,
                                               input logic ep, input logic [2:0] ef);
        hash_result_t r;
        logic [63:0] k;
        k = '0;
        r = '0;
        if (op == OP_FINISH)
        begin
            r.hash = pos_hash;
            r.done_res = 1'b1;
            pos_hash = '0;
            return r;
        end
        case (op)
            OP_PIECE:
                if (int'(c) < NUM_COLORS && int'(pt) < NUM_PIECE_TYPES)
                    k = zkeys[(int'(c) * NUM_PIECE_TYPES + int'(pt)) * 64 + int'(sq)];
            OP_SIDE:   if (sw) k = zkeys[SIDE_BASE];
            OP_CASTLE: k = zkeys[CASTLE_BASE + int'(cr)];
            OP_EP:     if (ep) k = zkeys[EP_BASE + int'(ef)];
            default:   k = '0;
        endcase
        pos_hash ^= k;
        r.key = k;
        r.hash = pos_hash;
        return r;
    endfunction

    // Reset reloads the table from the reset seed and clears the running hash.
    always @(posedge clk)
    begin
        hash_result_t exp_r;
        if (!rst_n)
        begin
            pos_hash = '0;
            hash_q.delete();
            build_keys(SEED_RESET);
        end
        else
        begin
            if (seed_we)
                build_keys(seed_wdata);
            if (result.valid && result.ready)
            begin
                if (hash_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = hash_q.pop_front();
                    if (result.key !== exp_r.key)
                    begin
                        $error("key: expected %h, got %h", exp_r.key, result.key);
                        fail_count++;
                    end
                    if (result.hash !== exp_r.hash)
                    begin
                        $error("hash: expected %h, got %h", exp_r.hash, result.hash);
                        fail_count++;
                    end
                    if (result.done_res !== exp_r.done_res)
                    begin
                        $error("done_res: expected %b, got %b", exp_r.done_res,
                               result.done_res);
                        fail_count++;
                    end
                end
            end
            if (term.valid && term.ready)
                hash_q.push_back(hash_term(term.opcode, term.color, term.pc_kind,
                                           term.square, term.side_white, term.castling,
                                           term.ep_present, term.ep_file));
        end
        pending = hash_q.size();
    end
endmodule

>>> bench/tb_zobrist_position_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zobrist_position_hasher_top
// Drives position terms in bursts under several seeds, with a stalling result
// side; the hash checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_zobrist_position_hasher_top;
    import zph_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        seed_we;
    logic [63:0] seed_wdata;
    int          fail_count;
    int          pending;
    int          burst_left;

    zph_term_if   term ();
    zph_result_if result ();

    zobrist_position_hasher_top DUT (
        .clk(clk), .rst_n(rst_n), .seed_we(seed_we), .seed_wdata(seed_wdata),
        .term(term.sink), .result(result.source)
    );

    zph_hash_checker checker_i (
        .clk(clk), .rst_n(rst_n), .seed_we(seed_we), .seed_wdata(seed_wdata),
        .term(term), .result(result), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stall pattern: stretches of full rate alternate with random stalls.
    initial
    begin
        int phase;
        result.ready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if ((phase / 200) % 3 == 0)
                result.ready <= 1'b1;
            else
                result.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_term(input logic [2:0] op, input logic c, input logic [2:0] pt,
                             input logic [5:0] sq, input logic sw, input logic [3:0] cr,
                             input logic ep, input logic [2:0] ef);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        term.valid <= 1'b1;
        term.opcode <= op;
        term.color <= c;
        term.pc_kind <= pt;
        term.square <= sq;
        term.side_white <= sw;
        term.castling <= cr;
        term.ep_present <= ep;
        term.ep_file <= ef;
        do
            @(posedge clk);
        while (!term.ready);
        @(negedge clk);
        if (burst_left == 0 || $urandom_range(0, 7) == 0)
        begin
            term.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic send_random();
        int pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 55)      op = OP_PIECE;
        else if (pick < 65) op = OP_SIDE;
        else if (pick < 75) op = OP_CASTLE;
        else if (pick < 85) op = OP_EP;
        else if (pick < 95) op = OP_FINISH;
        else                op = 3'($urandom_range(5, 7));
        send_term(op, 1'($urandom), 3'($urandom), 6'($urandom), 1'($urandom),
                  4'($urandom), 1'($urandom), 3'($urandom));
    endtask

    // Lets the pipeline drain before a seed write, then writes the seed.
    task automatic write_seed(input logic [63:0] s);
        // A burst still open holds valid high; a closed one already dropped it.
        if (burst_left != 0)
            term.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        seed_we <= 1'b1;
        seed_wdata <= s;
        @(negedge clk);
        seed_we <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] seeds[4];
        seeds[0] = 64'd0;
        seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = 64'h5555_AAAA_0F0F_F0F0;
        rst_n = 1'b0;
        seed_we = 1'b0;
        seed_wdata = '0;
        burst_left = 0;
        term.valid = 1'b0;
        term.opcode = '0;
        term.color = 1'b0;
        term.pc_kind = '0;
        term.square = '0;
        term.side_white = 1'b0;
        term.castling = '0;
        term.ep_present = 1'b0;
        term.ep_file = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Corners of every field, absent terms, out-of-range types, unused opcodes.
        send_term(OP_PIECE, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_PIECE, 1'b1, 3'd5, 6'd63, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_PIECE, 1'b1, 3'd6, 6'd10, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_PIECE, 1'b0, 3'd7, 6'd63, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_SIDE, 1'b0, 3'd0, 6'd0, 1'b1, 4'd0, 1'b0, 3'd0);
        send_term(OP_SIDE, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_CASTLE, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_CASTLE, 1'b0, 3'd0, 6'd0, 1'b0, 4'd15, 1'b0, 3'd0);
        send_term(OP_EP, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b1, 3'd0);
        send_term(OP_EP, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b1, 3'd7);
        send_term(OP_EP, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b0, 3'd5);
        send_term(3'd5, 1'b1, 3'd2, 6'd9, 1'b1, 4'd3, 1'b1, 3'd2);
        send_term(3'd7, 1'b1, 3'd7, 6'd63, 1'b1, 4'd15, 1'b1, 3'd7);
        send_term(OP_FINISH, 1'b0, 3'd0, 6'd0, 1'b0, 4'd0, 1'b0, 3'd0);
        send_term(OP_FINISH, 1'b1, 3'd7, 6'd63, 1'b1, 4'd15, 1'b1, 3'd7);

        // The hash carries across a seed write, so a phase may open mid-position.
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                write_seed(seeds[ph - 1]);
            for (int n = 0; n < 200; n++)
                send_random();
        end

        if (burst_left != 0)
            term.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

>>> zobrist_position_hasher_top.f
+incdir+hdl
hdl/zph_pkg.sv
hdl/zph_stream_if.sv
hdl/zph_key_gen.sv
hdl/zph_term_unit.sv
hdl/zobrist_position_hasher_top.sv
bench/zph_tb_if.sv
bench/zph_hash_checker.sv
bench/tb_zobrist_position_hasher_top.sv
